>>> design/fba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_pkg: frame bitmap allocator package
// Command codes, beat types, controller states and the free-bit search.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned BIT_W       = 6;
  localparam int unsigned ADDR_W      = 28;
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned WIDX_W      = ADDR_W - FRAME_SHIFT - BIT_W;
  localparam int unsigned CFG_W       = 11;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_TEST  = 2'd2,
    CMD_FIND  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] phys_address;
  } request_t;

  typedef struct packed {
    logic              frame_used;
    logic [ADDR_W-1:0] free_address;
    logic              none_free;
  } result_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_SCAN
  } state_t;

  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> design/frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator: bitmap page frame allocator
// One bit per 4 KiB frame in a 64-bit word memory; set, clear, test, find.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a command beat on request with start; it is taken at an edge where
//   start is high and busy is low. Each command gives exactly one result beat
//   on result, marked by done for one cycle; the receiver cannot stall it.
//   Set, clear and test do one memory read, then the modify and write-back
//   through the single write port. The result shows in the cycle after the
//   write-back, when busy is already low again.
//   Find reads one bitmap word per cycle from the read port, with the check
//   one word behind the read; it stops at the first word with a free bit, or
//   at the scan limit, the lower of words_in_use and BITMAP_WORDS, when none
//   is free; a scan limit of zero reads no word and answers none free.
//   words_in_use is written through cfg_wr_en / cfg_wr_data; the user must
//   write it only while idle, as the block itself does not enforce this.
//   After reset the bitmap memory is swept to zero, one word per cycle, with
//   busy high until every word is written; configuration writes still land.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
  parameter int unsigned BITMAP_WORDS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  fba_pkg::request_t               request,
  output logic                            done,
  output fba_pkg::result_t                result,
  input  logic                            cfg_wr_en,
  input  logic [fba_pkg::CFG_W-1:0]       cfg_wr_data
);

  localparam int unsigned AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int unsigned IW = $clog2(BITMAP_WORDS + 1);
  localparam int unsigned LW = (IW > fba_pkg::CFG_W) ? IW : fba_pkg::CFG_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(BITMAP_WORDS);
  localparam logic [AW-1:0] LAST_IDX = AW'(BITMAP_WORDS - 1);

  logic [fba_pkg::WORD_BITS-1:0] mem [BITMAP_WORDS];
  logic [fba_pkg::WORD_BITS-1:0] rd_data;

  fba_pkg::state_t state, state_next;

  logic [fba_pkg::CFG_W-1:0]  words_in_use;
  logic [AW-1:0]              clr_idx;
  fba_pkg::cmd_t              req_cmd;
  logic [fba_pkg::WIDX_W-1:0] req_word;
  logic [fba_pkg::BIT_W-1:0]  req_bit;
  logic                       req_in_range;
  logic [LW-1:0]              scan_limit;
  logic [LW-1:0]              issue_idx;
  logic [LW-1:0]              chk_idx;
  logic                       pend;

  logic                       accept;
  logic [fba_pkg::WIDX_W-1:0] in_word;
  logic [fba_pkg::BIT_W-1:0]  in_bit;
  logic [LW-1:0]              limit_calc;
  logic                       issue_ok;
  logic                       scan_hit;
  logic                       scan_end;
  logic [fba_pkg::WORD_BITS-1:0] bit_mask;
  logic [fba_pkg::WORD_BITS-1:0] mod_word;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [fba_pkg::WORD_BITS-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;

  assign in_word    = request.phys_address[fba_pkg::ADDR_W-1 -: fba_pkg::WIDX_W];
  assign in_bit     = request.phys_address[fba_pkg::FRAME_SHIFT +: fba_pkg::BIT_W];
  assign accept     = start && !busy;
  assign limit_calc = (LW'(words_in_use) > DEPTH_L) ? DEPTH_L : LW'(words_in_use);
  assign issue_ok   = issue_idx < scan_limit;
  assign scan_hit   = pend && (rd_data != '1);
  assign scan_end   = !pend && !issue_ok;
  assign bit_mask   = fba_pkg::WORD_BITS'(1) << req_bit;
  assign mod_word   = (req_cmd == fba_pkg::CMD_SET) ? (rd_data | bit_mask)
                                                    : (rd_data & ~bit_mask);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fba_pkg::S_CLEAR: begin
        if (clr_idx == LAST_IDX) state_next = fba_pkg::S_IDLE;
      end
      fba_pkg::S_IDLE: begin
        if (start) begin
          state_next = (request.cmd == fba_pkg::CMD_FIND) ? fba_pkg::S_SCAN
                                                           : fba_pkg::S_RMW;
        end
      end
      fba_pkg::S_RMW: begin
        state_next = fba_pkg::S_IDLE;
      end
      fba_pkg::S_SCAN: begin
        if (scan_hit || scan_end) state_next = fba_pkg::S_IDLE;
      end
      default: state_next = fba_pkg::S_CLEAR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = AW'(req_word);
    mem_wdata = mod_word;
    mem_re    = 1'b0;
    mem_raddr = AW'(in_word);
    unique case (state)
      fba_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      fba_pkg::S_IDLE: begin
        busy   = 1'b0;
        mem_re = start;
      end
      fba_pkg::S_RMW: begin
        mem_we = req_in_range && (req_cmd == fba_pkg::CMD_SET ||
                                  req_cmd == fba_pkg::CMD_CLEAR);
      end
      fba_pkg::S_SCAN: begin
        mem_re    = issue_ok;
        mem_raddr = AW'(issue_idx);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fba_pkg::S_CLEAR;
      clr_idx      <= '0;
      words_in_use <= '0;
      done         <= 1'b0;
      pend         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_wr_en) words_in_use <= cfg_wr_data;
      if (state == fba_pkg::S_CLEAR) clr_idx <= clr_idx + AW'(1);
      if (accept) begin
        pend      <= 1'b0;
        issue_idx <= '0;
      end
      if (state == fba_pkg::S_RMW) begin
        done <= 1'b1;
      end
      if (state == fba_pkg::S_SCAN) begin
        // advance the read pointer, check one word behind it
        pend      <= issue_ok;
        chk_idx   <= issue_idx;
        issue_idx <= issue_idx + LW'(1);
        if (scan_hit || scan_end) begin
          done <= 1'b1;
          pend <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd      <= request.cmd;
      req_word     <= in_word;
      req_bit      <= in_bit;
      req_in_range <= LW'(in_word) < DEPTH_L;
      scan_limit   <= limit_calc;
    end
    if (state == fba_pkg::S_RMW) begin
      result.frame_used   <= (req_cmd == fba_pkg::CMD_TEST) && req_in_range &&
                             ((rd_data & bit_mask) != '0);
      result.free_address <= '0;
      result.none_free    <= 1'b0;
    end
    if (state == fba_pkg::S_SCAN && (scan_hit || scan_end)) begin
      result.frame_used <= 1'b0;
      result.none_free  <= !scan_hit;
      if (scan_hit) begin
        result.free_address <=
          (fba_pkg::ADDR_W'(chk_idx) << (fba_pkg::FRAME_SHIFT + fba_pkg::BIT_W)) |
          (fba_pkg::ADDR_W'(fba_pkg::first_zero(rd_data)) << fba_pkg::FRAME_SHIFT);
      end else begin
        result.free_address <= '0;
      end
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == fba_pkg::S_RMW || $past(state) == fba_pkg::S_SCAN))
    else $error("result beat without a command in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after accepting a command");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.none_free) |-> (result.free_address == '0))
    else $error("free address set while none free");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == fba_pkg::S_CLEAR) |-> !done)
    else $error("result beat during clearing sweep");

endmodule

>>> tb/fba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_checker: frame bitmap allocator result checker
// Watches the command, result and configuration ports of the allocator. It
// keeps its own copy of the frame bitmap and of the scan length, and works
// out the result of every accepted command. Each result beat is compared
// field by field with the oldest outstanding prediction. It reports the
// failure count and the number of results still owed.
// ----------------------------------------------------------------------------
module fba_checker #(
  parameter int unsigned BITMAP_WORDS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  fba_pkg::request_t         request,
  input  logic                      done,
  input  fba_pkg::result_t          result,
  input  logic                      cfg_wr_en,
  input  logic [fba_pkg::CFG_W-1:0] cfg_wr_data,
  output int                        fail_count,
  output int                        pending
);

  logic [fba_pkg::WORD_BITS-1:0] frame_map [BITMAP_WORDS];
  logic [fba_pkg::CFG_W-1:0]     scan_words;
  fba_pkg::result_t              owed_results [$];

  function automatic fba_pkg::result_t apply_command(fba_pkg::request_t req);
    fba_pkg::result_t          res;
    int unsigned               word_idx;
    logic [fba_pkg::BIT_W-1:0] bit_idx;
    int unsigned               limit;
    bit                        found;
    longint unsigned           frame_no;
    res      = '0;
    word_idx = 32'(req.phys_address[fba_pkg::ADDR_W-1 -: fba_pkg::WIDX_W]);
    bit_idx  = req.phys_address[fba_pkg::FRAME_SHIFT +: fba_pkg::BIT_W];
    case (req.cmd)
      fba_pkg::CMD_SET: begin
        if (word_idx < BITMAP_WORDS) frame_map[word_idx][bit_idx] = 1'b1;
      end
      fba_pkg::CMD_CLEAR: begin
        if (word_idx < BITMAP_WORDS) frame_map[word_idx][bit_idx] = 1'b0;
      end
      fba_pkg::CMD_TEST: begin
        if (word_idx < BITMAP_WORDS) res.frame_used = frame_map[word_idx][bit_idx];
      end
      default: begin
        limit = (32'(scan_words) > BITMAP_WORDS) ? BITMAP_WORDS : 32'(scan_words);
        found = 1'b0;
        for (int unsigned w = 0; w < limit && !found; w++) begin
          if (frame_map[w] != '1) begin
            for (int unsigned b = 0; b < fba_pkg::WORD_BITS && !found; b++) begin
              if (!frame_map[w][b]) begin
                found            = 1'b1;
                frame_no         = 64'(w) * 64'(fba_pkg::WORD_BITS) + 64'(b);
                res.free_address = fba_pkg::ADDR_W'(frame_no << fba_pkg::FRAME_SHIFT);
              end
            end
          end
        end
        res.none_free = !found;
      end
    endcase
    return res;
  endfunction

  task automatic log_failure(string what, fba_pkg::result_t want,
                             fba_pkg::result_t got);
    if (fail_count < 10) begin
      $display("%0t: %s: expected used=%0b addr=%07h none=%0b, got used=%0b addr=%07h none=%0b",
               $realtime, what, want.frame_used, want.free_address, want.none_free,
               got.frame_used, got.free_address, got.none_free);
    end
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    fba_pkg::result_t want;
    if (rst) begin
      foreach (frame_map[i]) frame_map[i] = '0;
      scan_words = '0;
      owed_results.delete();
    end else begin
      if (done) begin
        if (owed_results.size() == 0) begin
          log_failure("unexpected result beat", '0, result);
        end else begin
          want = owed_results.pop_front();
          if (want.frame_used != result.frame_used ||
              want.free_address != result.free_address ||
              want.none_free != result.none_free) begin
            log_failure("result mismatch", want, result);
          end
        end
      end
      if (start && !busy) owed_results.push_back(apply_command(request));
      if (cfg_wr_en) scan_words = cfg_wr_data;
    end
    pending = owed_results.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: frame bitmap allocator stimulus and verdict
// Drives a short directed sequence over the address extremes, every command
// and the scan-length corner cases, then random traffic biased towards the
// low bitmap words with whole-word fill bursts so that scans run past full
// words and report no free frame. The scan length is changed between phases,
// and the command gaps go from light to heavy to none.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned BITMAP_WORDS = 1024;
  localparam int unsigned HOT_WORDS    = 4;
  localparam int          CYCLE_LIMIT  = 5000000;

  logic                      clk;
  logic                      rst         = 1'b1;
  logic                      start       = 1'b0;
  logic                      cfg_wr_en   = 1'b0;
  logic [fba_pkg::CFG_W-1:0] cfg_wr_data = '0;
  fba_pkg::request_t         request     = '0;
  logic                      busy;
  logic                      done;
  fba_pkg::result_t          result;
  int                        fail_count;
  int                        pending;
  int                        cycle_count = 0;
  int                        gap_pct     = 0;

  frame_bitmap_allocator #(.BITMAP_WORDS(BITMAP_WORDS)) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  fba_checker #(.BITMAP_WORDS(BITMAP_WORDS)) alloc_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_command(fba_pkg::cmd_t op, logic [fba_pkg::ADDR_W-1:0] addr);
    start   <= 1'b1;
    request <= fba_pkg::request_t'{cmd: op, phys_address: addr};
    @(posedge clk);
    while (busy) @(posedge clk);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_to_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_scan_words(logic [fba_pkg::CFG_W-1:0] value);
    drain_to_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [fba_pkg::ADDR_W-1:0] hot_address();
    int unsigned frame_no;
    frame_no = $urandom_range(0, HOT_WORDS * fba_pkg::WORD_BITS - 1);
    return fba_pkg::ADDR_W'(frame_no << fba_pkg::FRAME_SHIFT) |
           fba_pkg::ADDR_W'($urandom_range(0, 4095));
  endfunction

  task automatic random_traffic(int count);
    int          sent;
    int unsigned pick;
    int unsigned fill_word;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_command(fba_pkg::CMD_SET, hot_address());
      end else if (pick < 42) begin
        send_command(fba_pkg::CMD_CLEAR, hot_address());
      end else if (pick < 55) begin
        send_command(fba_pkg::CMD_TEST, hot_address());
      end else if (pick < 75) begin
        send_command(fba_pkg::CMD_FIND, fba_pkg::ADDR_W'($urandom));
      end else if (pick < 95) begin
        send_command(fba_pkg::cmd_t'($urandom_range(0, 3)), fba_pkg::ADDR_W'($urandom));
      end else begin
        // fill one hot word completely, then look for a frame
        fill_word = $urandom_range(0, HOT_WORDS - 1);
        for (int unsigned b = 0; b < fba_pkg::WORD_BITS; b++) begin
          send_command(fba_pkg::CMD_SET,
                       fba_pkg::ADDR_W'((fill_word * fba_pkg::WORD_BITS + b) <<
                                        fba_pkg::FRAME_SHIFT) |
                       fba_pkg::ADDR_W'($urandom_range(0, 4095)));
        end
        send_command(fba_pkg::CMD_FIND, '0);
        sent += fba_pkg::WORD_BITS;
      end
      sent++;
    end
  endtask

  initial begin
    logic [fba_pkg::CFG_W-1:0] phase_words [9];
    phase_words = '{11'd1, 11'd2047, 11'd3, 11'd0, 11'd1024, 11'd2,
                    11'd1, 11'd1024, 11'd4};
    phase_words[6] = fba_pkg::CFG_W'($urandom_range(0, 2047));
    gap_pct = 19;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    drain_to_idle();

    send_command(fba_pkg::CMD_FIND, 28'h0000000);
    send_command(fba_pkg::CMD_TEST, 28'h0000000);
    send_command(fba_pkg::CMD_SET, 28'h0000fff);
    send_command(fba_pkg::CMD_TEST, 28'h0000000);
    send_command(fba_pkg::CMD_SET, 28'hfffffff);
    send_command(fba_pkg::CMD_TEST, 28'hffff000);
    write_scan_words(11'd2047);
    send_command(fba_pkg::CMD_FIND, 28'hfffffff);
    send_command(fba_pkg::CMD_SET, 28'h0001abc);
    write_scan_words(11'd1);
    send_command(fba_pkg::CMD_FIND, 28'h0000000);
    send_command(fba_pkg::CMD_CLEAR, 28'h0000000);
    send_command(fba_pkg::CMD_FIND, 28'h0000000);
    send_command(fba_pkg::CMD_CLEAR, 28'hfffffff);
    send_command(fba_pkg::CMD_TEST, 28'hfffffff);
    send_command(fba_pkg::CMD_CLEAR, 28'h0001000);

    for (int p = 0; p < 9; p++) begin
      gap_pct = (p < 3) ? 19 : (p < 6) ? 68 : 0;
      write_scan_words(phase_words[p]);
      random_traffic(120);
    end

    drain_to_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
